>>> src/geex_pkg.sv
// Shared constants, types and helpers for the glyph extent extractor.
// Used by the channel interfaces, the raster position unit and the top level.
// Depends on nothing.
package geex_pkg;

   // Sheet geometry.
   localparam int GRID_CELLS    = 16;
   localparam int MAX_CELL_SIZE = 64;
   localparam int GLYPH_COUNT   = 256;

   // Field and counter widths.
   localparam int GRID_BITS      = $clog2(GRID_CELLS);
   localparam int CELL_BITS      = $clog2(MAX_CELL_SIZE);
   localparam int CODE_BITS      = $clog2(GLYPH_COUNT);
   localparam int SIZE_BITS      = 7;
   localparam int POS_BITS       = 10;
   localparam int PIXEL_BITS     = 32;
   localparam int COORD_BITS     = 10;
   localparam int SPACE_BITS     = 6;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [GRID_BITS-1:0] GRID_LAST       = GRID_BITS'(GRID_CELLS - 1);
   localparam logic [CODE_BITS-1:0] LETTER_A        = CODE_BITS'(65);
   localparam logic [SIZE_BITS-1:0] RESET_CELL_SIZE = SIZE_BITS'(8);
   localparam logic [SIZE_BITS-1:0] MAX_SIZE_VALUE  = SIZE_BITS'(MAX_CELL_SIZE);
   localparam logic [COORD_BITS:0]  COORD_MAX       = (COORD_BITS+1)'((1 << COORD_BITS) - 1);

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CELL_WIDTH  = 1'b0,
      CSR_CELL_HEIGHT = 1'b1
   } csr_index_type;

   // Raster position unit states.
   typedef enum logic [1:0] {
      POS_READY,
      POS_WRAP,
      POS_DIVIDE
   } pos_state_type;

   // One cell entry of the extent memory.
   typedef struct packed {
      logic                 inked;
      logic [CELL_BITS-1:0] right;
      logic [CELL_BITS-1:0] left;
   } extent_type;

   // Where the next sheet pixel lands, from the raster position unit.
   typedef struct packed {
      logic                 ready;
      logic                 sheet_start;
      logic                 cell_start;
      logic [CELL_BITS-1:0] local_col;
      logic [CELL_BITS-1:0] local_row;
      logic [CODE_BITS-1:0] cell_index;
   } pos_type;

   // A cell size of zero acts as one, and anything above the maximum is clamped.
   function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] value);
      logic [SIZE_BITS-1:0] result;
      result = value;
      if (value == '0) begin
         result = SIZE_BITS'(1);
      end else if (value > MAX_SIZE_VALUE) begin
         result = MAX_SIZE_VALUE;
      end
      return result;
   endfunction

endpackage

>>> src/geex_channels.sv
// Valid/ready channel interfaces for the glyph extent extractor:
// the request, response and configuration write channels.
// Depends on geex_pkg for the payload widths.
interface geex_req_if;
   logic                             valid;
   logic                             ready;
   logic                             action;
   logic [geex_pkg::PIXEL_BITS-1:0]  pixel;
   logic [geex_pkg::CODE_BITS-1:0]   glyph_code;

   modport source (output valid, action, pixel, glyph_code, input ready);
   modport sink   (input valid, action, pixel, glyph_code, output ready);
endinterface

interface geex_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [geex_pkg::COORD_BITS-1:0]  glyph_x;
   logic [geex_pkg::COORD_BITS-1:0]  glyph_y;
   logic [geex_pkg::SIZE_BITS-1:0]   glyph_width;
   logic [geex_pkg::SIZE_BITS-1:0]   glyph_height;
   logic [geex_pkg::SPACE_BITS-1:0]  space_width;
   logic [geex_pkg::SIZE_BITS-1:0]   line_height;

   modport source (output valid, glyph_x, glyph_y, glyph_width, glyph_height,
                   space_width, line_height, input ready);
   modport sink   (input valid, glyph_x, glyph_y, glyph_width, glyph_height,
                   space_width, line_height, output ready);
endinterface

interface geex_csr_if;
   logic                                valid;
   logic                                ready;
   logic [geex_pkg::CSR_INDEX_BITS-1:0] index;
   logic [geex_pkg::SIZE_BITS-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> src/geex_raster_pos.sv
// Raster position unit: tracks the sheet column and row of the next pixel and
// keeps them split into cell index and offset inside the cell.
// Depends on geex_pkg.
module geex_raster_pos (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [geex_pkg::SIZE_BITS-1:0]   cell_width,
   input  logic [geex_pkg::SIZE_BITS-1:0]   cell_height,
   input  logic                             step,
   input  logic                             cfg_write,
   output geex_pkg::pos_type                pos
);

   geex_pkg::pos_state_type state_ff, state_in;

   logic [geex_pkg::POS_BITS-1:0]  col_ff, col_in, row_ff, row_in;
   logic [geex_pkg::POS_BITS-1:0]  col_rem_ff, col_rem_in, row_rem_ff, row_rem_in;
   logic [geex_pkg::CELL_BITS-1:0] lc_ff, lc_in, lr_ff, lr_in;
   logic [geex_pkg::GRID_BITS-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [1:0]                     bit_ff, bit_in;

   logic [geex_pkg::POS_BITS:0]    sheet_w, sheet_h, wrap_row;
   logic [geex_pkg::POS_BITS-1:0]  div_col, div_row;
   logic                           last_col, last_row;

   // Position registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= geex_pkg::POS_READY;
         col_ff     <= '0;
         row_ff     <= '0;
         lc_ff      <= '0;
         lr_ff      <= '0;
         cx_ff      <= '0;
         cy_ff      <= '0;
         bit_ff     <= '0;
         col_rem_ff <= '0;
         row_rem_ff <= '0;
      end else begin
         state_ff   <= state_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         lc_ff      <= lc_in;
         lr_ff      <= lr_in;
         cx_ff      <= cx_in;
         cy_ff      <= cy_in;
         bit_ff     <= bit_in;
         col_rem_ff <= col_rem_in;
         row_rem_ff <= row_rem_in;
      end
   end

   // Advance on each pixel; after a size change, wrap the counters against the
   // new sheet size and split them again with a four-step restoring division.
   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      lc_in      = lc_ff;
      lr_in      = lr_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      bit_in     = bit_ff;
      col_rem_in = col_rem_ff;
      row_rem_in = row_rem_ff;

      sheet_w  = {cell_width, {geex_pkg::GRID_BITS{1'b0}}};
      sheet_h  = {cell_height, {geex_pkg::GRID_BITS{1'b0}}};
      wrap_row = {1'b0, row_ff};
      div_col  = geex_pkg::POS_BITS'(cell_width) << bit_ff;
      div_row  = geex_pkg::POS_BITS'(cell_height) << bit_ff;
      last_col = (geex_pkg::SIZE_BITS'(lc_ff) + geex_pkg::SIZE_BITS'(1)) == cell_width;
      last_row = (geex_pkg::SIZE_BITS'(lr_ff) + geex_pkg::SIZE_BITS'(1)) == cell_height;

      case (state_ff)
         geex_pkg::POS_READY: begin
            if (step) begin
               if (last_col) begin
                  lc_in = '0;
                  if (cx_ff == geex_pkg::GRID_LAST) begin
                     // End of a sheet row: move down one pixel row.
                     cx_in  = '0;
                     col_in = '0;
                     if (last_row) begin
                        lr_in = '0;
                        if (cy_ff == geex_pkg::GRID_LAST) begin
                           cy_in  = '0;
                           row_in = '0;
                        end else begin
                           cy_in  = cy_ff + 1'b1;
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        lr_in  = lr_ff + 1'b1;
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     cx_in  = cx_ff + 1'b1;
                     col_in = col_ff + 1'b1;
                  end
               end else begin
                  lc_in  = lc_ff + 1'b1;
                  col_in = col_ff + 1'b1;
               end
            end
         end
         geex_pkg::POS_WRAP: begin
            if ({1'b0, col_ff} >= sheet_w) begin
               col_in   = '0;
               wrap_row = {1'b0, row_ff} + 1'b1;
            end
            if (wrap_row >= sheet_h) begin
               wrap_row = '0;
            end
            row_in     = wrap_row[geex_pkg::POS_BITS-1:0];
            col_rem_in = col_in;
            row_rem_in = row_in;
            cx_in      = '0;
            cy_in      = '0;
            bit_in     = 2'd3;
            state_in   = geex_pkg::POS_DIVIDE;
         end
         geex_pkg::POS_DIVIDE: begin
            if (col_rem_ff >= div_col) begin
               col_rem_in    = col_rem_ff - div_col;
               cx_in[bit_ff] = 1'b1;
            end
            if (row_rem_ff >= div_row) begin
               row_rem_in    = row_rem_ff - div_row;
               cy_in[bit_ff] = 1'b1;
            end
            if (bit_ff == 2'd0) begin
               lc_in    = col_rem_in[geex_pkg::CELL_BITS-1:0];
               lr_in    = row_rem_in[geex_pkg::CELL_BITS-1:0];
               state_in = geex_pkg::POS_READY;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         default: begin
            state_in = geex_pkg::POS_READY;
         end
      endcase

      // A size write restarts the split with the newest sizes.
      if (cfg_write) begin
         state_in = geex_pkg::POS_WRAP;
      end
   end

   // Position of the next pixel.
   always_comb begin
      pos.ready       = state_ff == geex_pkg::POS_READY;
      pos.sheet_start = (col_ff == '0) && (row_ff == '0);
      pos.cell_start  = (lc_ff == '0) && (lr_ff == '0);
      pos.local_col   = lc_ff;
      pos.local_row   = lr_ff;
      pos.cell_index  = {cy_ff, cx_ff};
   end

   // The in-cell offsets stay inside the current cell size whenever pixels are taken.
   a_offset_in_cell: assert property (@(posedge clock) disable iff (reset)
      state_ff == geex_pkg::POS_READY |->
         (geex_pkg::SIZE_BITS'(lc_ff) < cell_width) &&
         (geex_pkg::SIZE_BITS'(lr_ff) < cell_height))
      else $error("raster offset outside the cell");

   // Pixels are only stepped while no counter split is in progress.
   a_step_when_ready: assert property (@(posedge clock) disable iff (reset)
      step |-> state_ff == geex_pkg::POS_READY)
      else $error("pixel stepped during a counter split");

   // The division ends after its last quotient bit.
   a_divide_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == geex_pkg::POS_DIVIDE && bit_ff == 2'd0 && !cfg_write |=>
         state_ff == geex_pkg::POS_READY)
      else $error("counter split did not finish");

endmodule

>>> src/glyph_extent_extractor_core.sv
// Top level of the glyph extent extractor: cell extent memory with its
// read-modify-write stage, sheet-wide trims and the query response register.
// Depends on geex_pkg, geex_channels and geex_raster_pos.
//
//   Port       Role     Beat contents
//   req_bus    sink     action, pixel, glyph_code
//   rsp_bus    source   glyph_x, glyph_y, glyph_width, glyph_height,
//                       space_width, line_height (one beat per query)
//   csr_bus    sink     index (0 cell_width, 1 cell_height), data
//
// One request beat per cycle while req_bus.ready is high: a pixel reads its
// cell entry from the extent memory and writes it back in the next cycle,
// with the last write forwarded. A query beat goes through the update stage
// and the response register to rsp_bus. A csr_bus write holds req_bus.ready
// low while the raster counters are split again by the new cell size.
// Reset clears the control state; the extent memory keeps its contents.
// A query held by a stalled rsp_bus holds req_bus.ready low until taken.
module glyph_extent_extractor_core (
   input  logic       clock,
   input  logic       reset,
   geex_req_if.sink   req_bus,
   geex_rsp_if.source rsp_bus,
   geex_csr_if.sink   csr_bus
);

   // Configuration.
   logic [geex_pkg::SIZE_BITS-1:0]  cw_cfg_ff, ch_cfg_ff;
   logic [geex_pkg::SIZE_BITS-1:0]  cw_eff, ch_eff;
   logic                            cfg_write;

   // Sheet-wide state.
   logic [geex_pkg::PIXEL_BITS-1:0] bg_ff, bg_in;
   logic [geex_pkg::SIZE_BITS-1:0]  top_ff, top_in, abot_ff, abot_in;

   // Request stage.
   geex_pkg::pos_type               pos;
   logic                            accept, pix_accept, ink_s0;
   logic [geex_pkg::CODE_BITS-1:0]  rd_addr;

   // Extent memory and read-modify-write stage.
   geex_pkg::extent_type            ext_mem [geex_pkg::GLYPH_COUNT];
   geex_pkg::extent_type            rdata_ff;
   logic                            s1_valid_ff, s1_query_ff, s1_ink_ff, s1_cell_start_ff;
   logic [geex_pkg::CODE_BITS-1:0]  s1_idx_ff;
   logic [geex_pkg::CELL_BITS-1:0]  s1_lc_ff;
   logic                            s1_stall, mem_we;
   geex_pkg::extent_type            entry_rd, entry_base, wr_entry;
   logic                            wr_valid_ff;
   logic [geex_pkg::CODE_BITS-1:0]  wr_idx_ff;
   geex_pkg::extent_type            wr_data_ff;

   // Query arithmetic and response register.
   logic [geex_pkg::COORD_BITS:0]   x_sum, y_sum;
   logic [geex_pkg::COORD_BITS-1:0] q_x, q_y;
   logic [geex_pkg::SIZE_BITS-1:0]  q_w, q_h, q_lh;
   logic                            out_load, out_valid_ff;
   logic [geex_pkg::COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic [geex_pkg::SIZE_BITS-1:0]  out_w_ff, out_h_ff, out_lh_ff;
   logic [geex_pkg::SPACE_BITS-1:0] out_space_ff;

   // Configuration registers; writes are always taken.
   assign csr_bus.ready = 1'b1;
   assign cfg_write     = csr_bus.valid;
   assign cw_eff        = geex_pkg::eff_size(cw_cfg_ff);
   assign ch_eff        = geex_pkg::eff_size(ch_cfg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cw_cfg_ff <= geex_pkg::RESET_CELL_SIZE;
         ch_cfg_ff <= geex_pkg::RESET_CELL_SIZE;
      end else if (cfg_write) begin
         case (geex_pkg::csr_index_type'(csr_bus.index))
            geex_pkg::CSR_CELL_WIDTH:  cw_cfg_ff <= csr_bus.data;
            geex_pkg::CSR_CELL_HEIGHT: ch_cfg_ff <= csr_bus.data;
            default: begin
            end
         endcase
      end
   end

   // Raster position of the next pixel.
   geex_raster_pos u_pos (
      .clock       (clock),
      .reset       (reset),
      .cell_width  (cw_eff),
      .cell_height (ch_eff),
      .step        (pix_accept),
      .cfg_write   (cfg_write),
      .pos         (pos)
   );

   // Request handshake.
   assign s1_stall      = s1_valid_ff && s1_query_ff && out_valid_ff && !rsp_bus.ready;
   assign req_bus.ready = pos.ready && !s1_stall;
   assign accept        = req_bus.valid && req_bus.ready;
   assign pix_accept    = accept && !req_bus.action;
   assign ink_s0        = !pos.sheet_start && (req_bus.pixel != bg_ff);
   assign rd_addr       = req_bus.action ? req_bus.glyph_code : pos.cell_index;

   // Background, top trim and letter A bottom follow each pixel.
   always_comb begin
      bg_in   = bg_ff;
      top_in  = top_ff;
      abot_in = abot_ff;
      if (pix_accept) begin
         if (pos.sheet_start) begin
            bg_in   = req_bus.pixel;
            top_in  = ch_eff;
            abot_in = ch_eff;
         end
         if (ink_s0) begin
            if (geex_pkg::SIZE_BITS'(pos.local_row) < top_in) begin
               top_in = geex_pkg::SIZE_BITS'(pos.local_row);
            end
            if (pos.cell_index == geex_pkg::LETTER_A) begin
               abot_in = geex_pkg::SIZE_BITS'(pos.local_row);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff   <= '0;
         top_ff  <= geex_pkg::RESET_CELL_SIZE;
         abot_ff <= geex_pkg::RESET_CELL_SIZE;
      end else begin
         bg_ff   <= bg_in;
         top_ff  <= top_in;
         abot_ff <= abot_in;
      end
   end

   // Extent memory: one read per accepted beat, one write from the update stage.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ext_mem[s1_idx_ff] <= wr_entry;
      end
      if (accept) begin
         rdata_ff <= ext_mem[rd_addr];
      end
   end

   // Update stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!s1_stall) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_query_ff      <= req_bus.action;
         s1_idx_ff        <= rd_addr;
         s1_lc_ff         <= pos.local_col;
         s1_ink_ff        <= ink_s0;
         s1_cell_start_ff <= pos.cell_start;
      end
   end

   // Forward the last write when it hits the entry just read.
   assign entry_rd   = (wr_valid_ff && wr_idx_ff == s1_idx_ff) ? wr_data_ff : rdata_ff;
   assign entry_base = s1_cell_start_ff ? '0 : entry_rd;

   // Widen the inked span of the cell by the current column.
   always_comb begin
      wr_entry = entry_base;
      if (s1_ink_ff) begin
         wr_entry.inked = 1'b1;
         if (!entry_base.inked) begin
            wr_entry.left  = s1_lc_ff;
            wr_entry.right = s1_lc_ff;
         end else begin
            if (s1_lc_ff < entry_base.left) begin
               wr_entry.left = s1_lc_ff;
            end
            if (s1_lc_ff > entry_base.right) begin
               wr_entry.right = s1_lc_ff;
            end
         end
      end
   end

   assign mem_we = s1_valid_ff && !s1_query_ff && (s1_ink_ff || s1_cell_start_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (mem_we) begin
         wr_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wr_idx_ff  <= s1_idx_ff;
         wr_data_ff <= wr_entry;
      end
   end

   // Glyph rectangle for a query.
   always_comb begin
      x_sum = (geex_pkg::COORD_BITS+1)'(s1_idx_ff[geex_pkg::GRID_BITS-1:0]) *
              (geex_pkg::COORD_BITS+1)'(cw_eff);
      q_w   = cw_eff;
      if (entry_rd.inked) begin
         x_sum = x_sum + (geex_pkg::COORD_BITS+1)'(entry_rd.left);
         if (entry_rd.right >= entry_rd.left) begin
            q_w = geex_pkg::SIZE_BITS'(entry_rd.right) - geex_pkg::SIZE_BITS'(entry_rd.left)
                  + geex_pkg::SIZE_BITS'(1);
         end else begin
            q_w = '0;
         end
      end
      q_x = x_sum[geex_pkg::COORD_BITS-1:0];

      y_sum = (geex_pkg::COORD_BITS+1)'(s1_idx_ff[geex_pkg::CODE_BITS-1:geex_pkg::GRID_BITS]) *
              (geex_pkg::COORD_BITS+1)'(ch_eff) + (geex_pkg::COORD_BITS+1)'(top_ff);
      q_y   = (y_sum > geex_pkg::COORD_MAX) ? geex_pkg::COORD_MAX[geex_pkg::COORD_BITS-1:0]
                                            : y_sum[geex_pkg::COORD_BITS-1:0];
      q_h   = (ch_eff > top_ff) ? (ch_eff - top_ff) : '0;
      q_lh  = (abot_ff > top_ff) ? (abot_ff - top_ff) : '0;
   end

   // Response register.
   assign out_load = s1_valid_ff && s1_query_ff && !s1_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_load || (out_valid_ff && !rsp_bus.ready);
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_x_ff     <= q_x;
         out_y_ff     <= q_y;
         out_w_ff     <= q_w;
         out_h_ff     <= q_h;
         out_lh_ff    <= q_lh;
         out_space_ff <= cw_eff[geex_pkg::SIZE_BITS-1:1];
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.glyph_x      = out_x_ff;
   assign rsp_bus.glyph_y      = out_y_ff;
   assign rsp_bus.glyph_width  = out_w_ff;
   assign rsp_bus.glyph_height = out_h_ff;
   assign rsp_bus.space_width  = out_space_ff;
   assign rsp_bus.line_height  = out_lh_ff;

   // A stalled query keeps its place and its glyph code.
   a_stall_holds_query: assert property (@(posedge clock) disable iff (reset)
      s1_stall |=> s1_valid_ff && s1_query_ff && $stable(s1_idx_ff))
      else $error("stalled query lost from the update stage");

   // The first pixel of a sheet defines the background and is never ink.
   a_sheet_start_blank: assert property (@(posedge clock) disable iff (reset)
      pix_accept && pos.sheet_start |=> !s1_ink_ff)
      else $error("sheet start pixel treated as ink");

   // The forwarding record follows every extent write.
   a_forward_tracks_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> wr_valid_ff && wr_idx_ff == $past(s1_idx_ff))
      else $error("forwarding record missed an extent write");

endmodule
